FILE: rtl/sparkplug_session_sequence_check_macros.svh
// ----------------------------------------------------------------------------
// Sparkplug session sequence check - assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPARKPLUG_SESSION_SEQUENCE_CHECK_MACROS_SVH
`define SPARKPLUG_SESSION_SEQUENCE_CHECK_MACROS_SVH

// same-cycle implication
`define SPSC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SPSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/spsc_pkg.sv
// ----------------------------------------------------------------------------
// spsc_pkg
// Types and constants shared by the Sparkplug session sequence checker.
// ----------------------------------------------------------------------------
package spsc_pkg;

	localparam int NODE_IDX_W       = 4;
	localparam int DEV_IDX_W        = 3;
	localparam int SEQ_W            = 8;
	localparam int NODE_COUNT_DEF   = 16;
	localparam int DEV_PER_NODE_DEF = 8;

	typedef enum logic [3:0] {
		CMD_NBIRTH = 4'd0,
		CMD_NDEATH = 4'd1,
		CMD_NDATA  = 4'd2,
		CMD_DBIRTH = 4'd3,
		CMD_DDATA  = 4'd4,
		CMD_DDEATH = 4'd5,
		CMD_NCMD   = 4'd6,
		CMD_DCMD   = 4'd7,
		CMD_STATE  = 4'd8
	} command_t;

	typedef enum logic [2:0] {
		ST_OK             = 3'd0,
		ST_SEQ_GAP        = 3'd1,
		ST_BDSEQ_MISMATCH = 3'd2,
		ST_DEV_BIRTH_SEQ  = 3'd3,
		ST_NODE_BIRTH_SEQ = 3'd4,
		ST_MISSING_BDSEQ  = 3'd5,
		ST_NO_NODE_BIRTH  = 3'd6,
		ST_NO_DEV_BIRTH   = 3'd7
	} status_t;

	typedef struct packed {
		logic [3:0]            command;
		logic [NODE_IDX_W-1:0] node_index;
		logic [DEV_IDX_W-1:0]  device_index;
		logic                  has_seq;
		logic [SEQ_W-1:0]      seq_number;
		logic                  bdseq_present;
		logic [SEQ_W-1:0]      bdseq_value;
	} msg_word_t;

	typedef struct packed {
		logic             accepted;
		status_t          status;
		logic [SEQ_W-1:0] seq_expect;
	} res_word_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // word accepted: capture header, read tables
		logic commit;  // evaluate, write back, load result register
	} ctl_cmd_t;

endpackage

FILE: rtl/spsc_ctrl.sv
// ----------------------------------------------------------------------------
// spsc_ctrl
// Sequencer: accept one word, evaluate it, hand the result to the output
// register once that register is free.
// ----------------------------------------------------------------------------
module spsc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	output logic                msg_ready,
	output logic                res_valid,
	input  logic                res_ready,
	output spsc_pkg::ctl_cmd_t  ctl
);
	import spsc_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   res_valid_q;

	assign msg_ready  = (state_q == S_IDLE);
	assign res_valid  = res_valid_q;
	assign ctl.load   = msg_valid && (state_q == S_IDLE);
	assign ctl.commit = (state_q == S_EXEC) && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ctl.load) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (ctl.commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (ctl.commit)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/spsc_dpath.sv
// ----------------------------------------------------------------------------
// spsc_dpath
// Header register, node and device session tables, rule evaluation and the
// result register.
// ----------------------------------------------------------------------------
module spsc_dpath #(
	parameter int NODE_COUNT       = spsc_pkg::NODE_COUNT_DEF,
	parameter int DEVICES_PER_NODE = spsc_pkg::DEV_PER_NODE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_data,
	input  spsc_pkg::ctl_cmd_t  ctl,
	input  spsc_pkg::msg_word_t msg,
	output spsc_pkg::res_word_t res
);
	import spsc_pkg::*;

	// only indices the header fields can reach need storage
	localparam int NODE_SLOTS = (NODE_COUNT < 2**NODE_IDX_W) ? NODE_COUNT : 2**NODE_IDX_W;
	localparam int DEV_SLOTS  = (DEVICES_PER_NODE < 2**DEV_IDX_W) ?
	                            DEVICES_PER_NODE : 2**DEV_IDX_W;
	localparam int DEV_TOTAL  = NODE_SLOTS * DEV_SLOTS;
	localparam int NODE_AW    = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
	localparam int DEV_AW     = (DEV_TOTAL > 1) ? $clog2(DEV_TOTAL) : 1;

	logic                 check_en_q;
	msg_word_t            msg_q;
	logic                 node_in_q, dev_in_q;
	logic [NODE_AW-1:0]   node_addr, node_addr_q;
	logic [DEV_AW-1:0]    dev_addr, dev_addr_q;
	logic [31:0]          dev_lin;

	logic [NODE_SLOTS-1:0] node_birth_q;
	logic [DEV_TOTAL-1:0]  dev_birth_q;
	logic [SEQ_W-1:0]      node_bdseq_mem [NODE_SLOTS];
	logic [SEQ_W-1:0]      node_last_mem  [NODE_SLOTS];
	logic [SEQ_W-1:0]      dev_last_mem   [DEV_TOTAL];
	logic [SEQ_W-1:0]      node_bdseq_rd_q, node_last_rd_q, dev_last_rd_q;

	res_word_t        res_q;
	res_word_t        res_d;
	logic             active, dev_msg, node_born, dev_born;
	logic [SEQ_W-1:0] bd, node_next, dev_next;
	logic             wr_nbirth, wr_nlast, wr_dbirth, wr_dlast;

	assign res = res_q;

	assign node_addr = msg.node_index[NODE_AW-1:0];
	assign dev_lin   = 32'(msg.node_index) * 32'(DEV_SLOTS) + 32'(msg.device_index);
	assign dev_addr  = dev_lin[DEV_AW-1:0];

	// check enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) check_en_q <= 1'b1;
		else if (cfg_valid) check_en_q <= cfg_data;
	end

	// header capture and table reads
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			msg_q           <= msg;
			node_in_q       <= 32'(msg.node_index) < NODE_COUNT;
			dev_in_q        <= 32'(msg.device_index) < DEVICES_PER_NODE;
			node_addr_q     <= node_addr;
			dev_addr_q      <= dev_addr;
			node_bdseq_rd_q <= node_bdseq_mem[node_addr];
			node_last_rd_q  <= node_last_mem[node_addr];
			dev_last_rd_q   <= dev_last_mem[dev_addr];
		end
	end

	// rule evaluation
	assign dev_msg   = (msg_q.command == CMD_DBIRTH) || (msg_q.command == CMD_DDATA) ||
	                   (msg_q.command == CMD_DDEATH);
	assign active    = check_en_q && node_in_q && !(dev_msg && !dev_in_q) &&
	                   (msg_q.command <= CMD_DDEATH);
	assign node_born = node_birth_q[node_addr_q];
	assign dev_born  = dev_birth_q[dev_addr_q];
	assign bd        = msg_q.bdseq_present ? msg_q.bdseq_value : '0;
	assign node_next = node_last_rd_q + SEQ_W'(1);
	assign dev_next  = dev_last_rd_q + SEQ_W'(1);

	always_comb begin
		res_d.accepted   = 1'b1;
		res_d.status     = ST_OK;
		res_d.seq_expect = '0;
		wr_nbirth        = 1'b0;
		wr_nlast         = 1'b0;
		wr_dbirth        = 1'b0;
		wr_dlast         = 1'b0;
		if (active) begin
			case (command_t'(msg_q.command))
				CMD_NBIRTH: begin
					if (msg_q.has_seq && msg_q.seq_number != '0) begin
						res_d.accepted = 1'b0;
						res_d.status   = ST_NODE_BIRTH_SEQ;
					end else if (!msg_q.bdseq_present) begin
						res_d.accepted = 1'b0;
						res_d.status   = ST_MISSING_BDSEQ;
					end else begin
						wr_nbirth = 1'b1;
					end
				end
				CMD_NDEATH: begin
					if (node_born && bd != node_bdseq_rd_q) res_d.status = ST_BDSEQ_MISMATCH;
				end
				CMD_NDATA: begin
					if (!node_born) begin
						res_d.accepted = 1'b0;
						res_d.status   = ST_NO_NODE_BIRTH;
					end else begin
						res_d.seq_expect = node_next;
						if (msg_q.has_seq) begin
							wr_nlast = 1'b1;
							if (msg_q.seq_number != node_next) res_d.status = ST_SEQ_GAP;
						end
					end
				end
				CMD_DBIRTH: begin
					if (!node_born) begin
						res_d.accepted = 1'b0;
						res_d.status   = ST_NO_NODE_BIRTH;
					end else begin
						wr_dbirth = 1'b1;
						if (msg_q.has_seq && msg_q.seq_number != '0)
							res_d.status = ST_DEV_BIRTH_SEQ;
					end
				end
				CMD_DDATA: begin
					if (!node_born) begin
						res_d.accepted = 1'b0;
						res_d.status   = ST_NO_NODE_BIRTH;
					end else if (!dev_born) begin
						res_d.accepted = 1'b0;
						res_d.status   = ST_NO_DEV_BIRTH;
					end else begin
						res_d.seq_expect = dev_next;
						if (msg_q.has_seq) begin
							wr_dlast = 1'b1;
							if (msg_q.seq_number != dev_next) res_d.status = ST_SEQ_GAP;
						end
					end
				end
				default: ; // device death, commands, STATE: nothing to record
			endcase
		end
	end

	// birth flags, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_birth_q <= '0;
			dev_birth_q  <= '0;
		end else if (ctl.commit) begin
			if (wr_nbirth) node_birth_q[node_addr_q] <= 1'b1;
			if (wr_dbirth) dev_birth_q[dev_addr_q]   <= 1'b1;
		end
	end

	// table write-back
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			if (wr_nbirth) node_bdseq_mem[node_addr_q] <= bd;
			if (wr_nbirth) node_last_mem[node_addr_q]  <= '0;
			else if (wr_nlast) node_last_mem[node_addr_q] <= msg_q.seq_number;
			if (wr_dbirth) dev_last_mem[dev_addr_q] <= '0;
			else if (wr_dlast) dev_last_mem[dev_addr_q] <= msg_q.seq_number;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.commit) res_q <= res_d;
	end

endmodule

FILE: rtl/sparkplug_session_sequence_check.sv
// ----------------------------------------------------------------------------
// sparkplug_session_sequence_check
// Sparkplug B session and sequence checker for pre-parsed message headers.
// ----------------------------------------------------------------------------
// Each word on msg is one parsed message header (type, node, device, sequence
// and bdSeq with presence flags); each word on res is its verdict: accepted
// flag, status code and the expected sequence for node/device data. When a
// word is taken, the header is registered and the node and device sequence
// tables are read; the rules are then evaluated and the tables written
// back. The evaluate step waits while the result register still holds an
// untaken word, so a slow consumer holds off the next message. cfg_data
// writes check_enable (reset 1); with checking off every message passes with
// status 0 and the session state is left alone. Write it only while no
// message is in flight. Birth flags are cleared by reset; sequence and bdSeq
// tables need no clearing, as they are used only after a birth wrote them.
// ----------------------------------------------------------------------------
module sparkplug_session_sequence_check #(
	parameter int NODE_COUNT       = spsc_pkg::NODE_COUNT_DEF,
	parameter int DEVICES_PER_NODE = spsc_pkg::DEV_PER_NODE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// message header words
	input  logic                msg_valid,
	output logic                msg_ready,
	input  spsc_pkg::msg_word_t msg,
	// verdict words
	output logic                res_valid,
	input  logic                res_ready,
	output spsc_pkg::res_word_t res,
	// check_enable write
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);
	import spsc_pkg::*;

	`include "sparkplug_session_sequence_check_macros.svh"

	ctl_cmd_t ctl;

	// register writes always land at once
	assign cfg_ready = 1'b1;

	spsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.ctl       (ctl)
	);

	spsc_dpath #(
		.NODE_COUNT       (NODE_COUNT),
		.DEVICES_PER_NODE (DEVICES_PER_NODE)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.msg       (msg),
		.res       (res)
	);

	// one message in the evaluator at a time
	`SPSC_ASSERT_NEXT(a_one_in_flight, msg_valid && msg_ready, !msg_ready, "second word taken while busy")
	// a committed verdict is presented next cycle
	`SPSC_ASSERT_NEXT(a_commit_shows, ctl.commit, res_valid, "committed verdict not presented")
	// rejections carry only the hard-error codes
	`SPSC_ASSERT_IMPL(a_reject_code, res_valid && !res.accepted, res.status == ST_NODE_BIRTH_SEQ || res.status == ST_MISSING_BDSEQ || res.status == ST_NO_NODE_BIRTH || res.status == ST_NO_DEV_BIRTH, "reject with warning code")
	// an expected sequence only comes with accepted data
	`SPSC_ASSERT_IMPL(a_expect_data, res_valid && res.seq_expect != '0, res.accepted && (res.status == ST_OK || res.status == ST_SEQ_GAP), "seq_expect on non-data verdict")

endmodule
